@@ sv/decs_pkg.sv @@
// ============================================================================
// decs_pkg
// Shared widths, reset values and types of the disc collision step core.
// ============================================================================
`default_nettype none

package decs_pkg;

   // Field widths of the stream beats.
   localparam int WORD_W     = 32;
   localparam int MAG_W      = 31;
   localparam int FRAC_W     = 16;
   localparam int REQ_DATA_W = 352;
   localparam int RSP_DATA_W = 128;
   localparam int RSP_USER_W = 2;

   // Impulse divider: numerator, doubled denominator and quotient widths.
   // The quotient magnitude stays below 2^35 because the impulse can never
   // exceed twice the relative speed.
   localparam int NUM_W = 131;
   localparam int DEN_W = 95;
   localparam int QUO_W = 36;

   localparam logic [MAG_W-1:0] TIME_STEP_RESET = 31'd655;

   // Per-axis data that rides along with the divider.
   typedef struct packed {
      logic                     hit;
      logic                     add_q;
      logic signed [WORD_W-1:0] vel;
      logic signed [WORD_W-1:0] pos;
   } decs_side_type;

endpackage

`default_nettype wire

@@ sv/disc_elastic_collision_step_core.sv @@
// ============================================================================
// disc_elastic_collision_step_core
// One time step of a disc: optional 2D elastic impulse against a partner
// disc, then position update, all in saturating Q16.16.
// ============================================================================
//
//  channel | ports      | beat content
//  --------+------------+--------------------------------------------------
//  request | req_t*     | own and partner disc, radius sum; tuser = partner
//  result  | rsp_t*     | next position and velocity; tuser = flags
//  control | csr_*      | time step, unsigned Q15.16, written any cycle
//
// The core takes one request beat per clock cycle while not stalled.
// A beat passes from acceptance to its result beat through the product and
// sum stages, the impulse divider (one quotient bit per stage), the velocity
// clipping and position update stages, and the output register.
// Reset clears all valid bits and loads the time step with 655.
// A stalled result goes to a skid register; req_tready is low only while
// that skid register is full, and the whole pipeline then holds.
//
`default_nettype none

module disc_elastic_collision_step_core (
   input  logic                            clock,
   input  logic                            reset,
   // {own_x, own_y, own_vx, own_vy, own_mass, other_x, other_y, other_vx,
   //  other_vy, other_mass, contact_distance, pad} from bit 0 up
   input  logic [decs_pkg::REQ_DATA_W-1:0] req_tdata,
   // other_valid
   input  logic                            req_tuser,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // {next_x, next_y, next_vx, next_vy} from bit 0 up
   output logic [decs_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // {collided, saturated} from bit 0 up
   output logic [decs_pkg::RSP_USER_W-1:0] rsp_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic [decs_pkg::MAG_W-1:0]      csr_data,
   input  logic                            csr_valid,
   output logic                            csr_ready
);
   import decs_pkg::*;

   typedef struct packed {
      logic                     saturated;
      logic                     collided;
      logic signed [WORD_W-1:0] next_vy;
      logic signed [WORD_W-1:0] next_vx;
      logic signed [WORD_W-1:0] next_y;
      logic signed [WORD_W-1:0] next_x;
   } rsp_item_type;

   localparam logic signed [37:0] VEL_MAX = 38'sd2147483647;
   localparam logic signed [37:0] VEL_MIN = -38'sd2147483648;
   localparam logic signed [49:0] POS_MAX = 50'sd2147483647;
   localparam logic signed [49:0] POS_MIN = -50'sd2147483648;
   localparam logic [63:0]        ROUND_HALF = 64'(1) << (FRAC_W - 1);

   logic en;

   // ------------------------------------------------------------------
   // Time step register. Always ready; it must be written only while idle,
   // which the block itself does not enforce.
   logic [MAG_W-1:0] time_step_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         time_step_ff <= TIME_STEP_RESET;
      end else if (csr_valid) begin
         time_step_ff <= csr_data;
      end
   end

   // ------------------------------------------------------------------
   // Request fields.
   // ------------------------------------------------------------------
   logic signed [WORD_W-1:0] own_x, own_y, own_vx, own_vy;
   logic signed [WORD_W-1:0] other_x, other_y, other_vx, other_vy;
   logic [MAG_W-1:0]         own_mass, other_mass, contact_distance;

   assign own_x            = req_tdata[31:0];
   assign own_y            = req_tdata[63:32];
   assign own_vx           = req_tdata[95:64];
   assign own_vy           = req_tdata[127:96];
   assign own_mass         = req_tdata[158:128];
   assign other_x          = req_tdata[190:159];
   assign other_y          = req_tdata[222:191];
   assign other_vx         = req_tdata[254:223];
   assign other_vy         = req_tdata[286:255];
   assign other_mass       = req_tdata[317:287];
   assign contact_distance = req_tdata[348:318];

   // ------------------------------------------------------------------
   // Stage 1: position and velocity differences.
   // ------------------------------------------------------------------
   logic                     v1_ff;
   logic signed [32:0]       dx_1_ff, dy_1_ff, dvx_1_ff, dvy_1_ff;
   logic [MAG_W-1:0]         cd_1_ff, m1_1_ff, m2_1_ff;
   logic                     ov_1_ff;
   logic signed [WORD_W-1:0] px_1_ff, py_1_ff, vx_1_ff, vy_1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_tvalid;
      end
      if (en) begin
         dx_1_ff  <= 33'(own_x) - 33'(other_x);
         dy_1_ff  <= 33'(own_y) - 33'(other_y);
         dvx_1_ff <= 33'(own_vx) - 33'(other_vx);
         dvy_1_ff <= 33'(own_vy) - 33'(other_vy);
         cd_1_ff  <= contact_distance;
         m1_1_ff  <= own_mass;
         m2_1_ff  <= other_mass;
         ov_1_ff  <= req_tuser;
         px_1_ff  <= own_x;
         py_1_ff  <= own_y;
         vx_1_ff  <= own_vx;
         vy_1_ff  <= own_vy;
      end
   end

   // ------------------------------------------------------------------
   // Stage 2: squares and dot product terms.
   // ------------------------------------------------------------------
   logic signed [65:0] sq_dx, sq_dy, pr_dx, pr_dy;
   assign sq_dx = dx_1_ff * dx_1_ff;
   assign sq_dy = dy_1_ff * dy_1_ff;
   assign pr_dx = dx_1_ff * dvx_1_ff;
   assign pr_dy = dy_1_ff * dvy_1_ff;

   logic                     v2_ff;
   logic [64:0]              dxx_2_ff, dyy_2_ff;
   logic [61:0]              cc_2_ff;
   logic signed [65:0]       pdx_2_ff, pdy_2_ff;
   logic signed [32:0]       dx_2_ff, dy_2_ff;
   logic [MAG_W-1:0]         m1_2_ff, m2_2_ff;
   logic                     ov_2_ff;
   logic signed [WORD_W-1:0] px_2_ff, py_2_ff, vx_2_ff, vy_2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en) begin
         v2_ff <= v1_ff;
      end
      if (en) begin
         dxx_2_ff <= sq_dx[64:0];
         dyy_2_ff <= sq_dy[64:0];
         cc_2_ff  <= 62'(cd_1_ff) * 62'(cd_1_ff);
         pdx_2_ff <= pr_dx;
         pdy_2_ff <= pr_dy;
         dx_2_ff  <= dx_1_ff;
         dy_2_ff  <= dy_1_ff;
         m1_2_ff  <= m1_1_ff;
         m2_2_ff  <= m2_1_ff;
         ov_2_ff  <= ov_1_ff;
         px_2_ff  <= px_1_ff;
         py_2_ff  <= py_1_ff;
         vx_2_ff  <= vx_1_ff;
         vy_2_ff  <= vy_1_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 3: squared distance, dot product and the collision test.
   // ------------------------------------------------------------------
   logic [65:0]        d2_sum;
   logic signed [66:0] dot_sum;
   assign d2_sum  = 66'(dxx_2_ff) + 66'(dyy_2_ff);
   assign dot_sum = 67'(pdx_2_ff) + 67'(pdy_2_ff);

   logic                     v3_ff;
   logic [65:0]              d2_3_ff;
   logic signed [66:0]       dot_3_ff;
   logic                     hit_3_ff;
   logic [WORD_W-1:0]        msum_3_ff;
   logic signed [32:0]       dx_3_ff, dy_3_ff;
   logic [MAG_W-1:0]         m2_3_ff;
   logic signed [WORD_W-1:0] px_3_ff, py_3_ff, vx_3_ff, vy_3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (en) begin
         v3_ff <= v2_ff;
      end
      if (en) begin
         d2_3_ff   <= d2_sum;
         dot_3_ff  <= dot_sum;
         // Touching discs that approach each other: distance below the
         // radius sum and a negative dot product.
         hit_3_ff  <= ov_2_ff && (d2_sum < 66'(cc_2_ff)) && dot_sum[66];
         msum_3_ff <= 32'(m1_2_ff) + 32'(m2_2_ff);
         dx_3_ff   <= dx_2_ff;
         dy_3_ff   <= dy_2_ff;
         m2_3_ff   <= m2_2_ff;
         px_3_ff   <= px_2_ff;
         py_3_ff   <= py_2_ff;
         vx_3_ff   <= vx_2_ff;
         vy_3_ff   <= vy_2_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 4: magnitudes and the zero guards. On a hit the distance is
   // below 2^31 per axis and the squared distance fits 62 bits.
   // ------------------------------------------------------------------
   logic [66:0] dot_mag;
   logic [32:0] dx_mag, dy_mag;
   assign dot_mag = dot_3_ff[66] ? 67'(-dot_3_ff) : 67'(dot_3_ff);
   assign dx_mag  = dx_3_ff[32] ? 33'(-dx_3_ff) : 33'(dx_3_ff);
   assign dy_mag  = dy_3_ff[32] ? 33'(-dy_3_ff) : 33'(dy_3_ff);

   logic                     v4_ff;
   logic [61:0]              d2f_4_ff;
   logic [WORD_W-1:0]        msumf_4_ff;
   logic [65:0]              adot_4_ff;
   logic [MAG_W-1:0]         adx_4_ff, ady_4_ff;
   logic                     addx_4_ff, addy_4_ff;
   logic [WORD_W-1:0]        m2d_4_ff;
   logic                     hit_4_ff;
   logic signed [WORD_W-1:0] px_4_ff, py_4_ff, vx_4_ff, vy_4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (en) begin
         v4_ff <= v3_ff;
      end
      if (en) begin
         d2f_4_ff   <= (d2_3_ff == '0) ? 62'd1 : d2_3_ff[61:0];
         msumf_4_ff <= (msum_3_ff == '0) ? 32'd1 : msum_3_ff;
         adot_4_ff  <= dot_mag[65:0];
         adx_4_ff   <= dx_mag[30:0];
         ady_4_ff   <= dy_mag[30:0];
         // The dot product is negative on a hit, so the impulse points
         // along the distance: a non-negative distance adds the quotient.
         addx_4_ff  <= !dx_3_ff[32];
         addy_4_ff  <= !dy_3_ff[32];
         m2d_4_ff   <= {m2_3_ff, 1'b0};
         hit_4_ff   <= hit_3_ff;
         px_4_ff    <= px_3_ff;
         py_4_ff    <= py_3_ff;
         vx_4_ff    <= vx_3_ff;
         vy_4_ff    <= vy_3_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 5: partial products of the denominator and of |dot| * |d|.
   // ------------------------------------------------------------------
   logic                     v5_ff;
   logic [62:0]              den_lo_5_ff, den_hi_5_ff;
   logic [52:0]              pax0_5_ff, pax1_5_ff, pax2_5_ff;
   logic [52:0]              pay0_5_ff, pay1_5_ff, pay2_5_ff;
   logic [WORD_W-1:0]        m2d_5_ff;
   logic                     addx_5_ff, addy_5_ff, hit_5_ff;
   logic signed [WORD_W-1:0] px_5_ff, py_5_ff, vx_5_ff, vy_5_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else if (en) begin
         v5_ff <= v4_ff;
      end
      if (en) begin
         den_lo_5_ff <= 63'(msumf_4_ff) * 63'(d2f_4_ff[30:0]);
         den_hi_5_ff <= 63'(msumf_4_ff) * 63'(d2f_4_ff[61:31]);
         pax0_5_ff   <= 53'(adx_4_ff) * 53'(adot_4_ff[21:0]);
         pax1_5_ff   <= 53'(adx_4_ff) * 53'(adot_4_ff[43:22]);
         pax2_5_ff   <= 53'(adx_4_ff) * 53'(adot_4_ff[65:44]);
         pay0_5_ff   <= 53'(ady_4_ff) * 53'(adot_4_ff[21:0]);
         pay1_5_ff   <= 53'(ady_4_ff) * 53'(adot_4_ff[43:22]);
         pay2_5_ff   <= 53'(ady_4_ff) * 53'(adot_4_ff[65:44]);
         m2d_5_ff    <= m2d_4_ff;
         addx_5_ff   <= addx_4_ff;
         addy_5_ff   <= addy_4_ff;
         hit_5_ff    <= hit_4_ff;
         px_5_ff     <= px_4_ff;
         py_5_ff     <= py_4_ff;
         vx_5_ff     <= vx_4_ff;
         vy_5_ff     <= vy_4_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 6: sum the partial products.
   // ------------------------------------------------------------------
   logic                     v6_ff;
   logic [93:0]              den_6_ff;
   logic [96:0]              ax_6_ff, ay_6_ff;
   logic [WORD_W-1:0]        m2d_6_ff;
   logic                     addx_6_ff, addy_6_ff, hit_6_ff;
   logic signed [WORD_W-1:0] px_6_ff, py_6_ff, vx_6_ff, vy_6_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff <= 1'b0;
      end else if (en) begin
         v6_ff <= v5_ff;
      end
      if (en) begin
         den_6_ff  <= 94'(den_lo_5_ff) + (94'(den_hi_5_ff) << 31);
         ax_6_ff   <= 97'(pax0_5_ff) + (97'(pax1_5_ff) << 22) + (97'(pax2_5_ff) << 44);
         ay_6_ff   <= 97'(pay0_5_ff) + (97'(pay1_5_ff) << 22) + (97'(pay2_5_ff) << 44);
         m2d_6_ff  <= m2d_5_ff;
         addx_6_ff <= addx_5_ff;
         addy_6_ff <= addy_5_ff;
         hit_6_ff  <= hit_5_ff;
         px_6_ff   <= px_5_ff;
         py_6_ff   <= py_5_ff;
         vx_6_ff   <= vx_5_ff;
         vy_6_ff   <= vy_5_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 7: partial products of the numerator 2*m2*|dot|*|d|.
   // ------------------------------------------------------------------
   logic                     v7_ff;
   logic [56:0]              nx0_7_ff, nx1_7_ff, nx2_7_ff, nx3_7_ff;
   logic [56:0]              ny0_7_ff, ny1_7_ff, ny2_7_ff, ny3_7_ff;
   logic [93:0]              den_7_ff;
   logic                     addx_7_ff, addy_7_ff, hit_7_ff;
   logic signed [WORD_W-1:0] px_7_ff, py_7_ff, vx_7_ff, vy_7_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v7_ff <= 1'b0;
      end else if (en) begin
         v7_ff <= v6_ff;
      end
      if (en) begin
         nx0_7_ff  <= 57'(m2d_6_ff) * 57'(ax_6_ff[24:0]);
         nx1_7_ff  <= 57'(m2d_6_ff) * 57'(ax_6_ff[49:25]);
         nx2_7_ff  <= 57'(m2d_6_ff) * 57'(ax_6_ff[74:50]);
         nx3_7_ff  <= 57'(m2d_6_ff) * 57'(ax_6_ff[96:75]);
         ny0_7_ff  <= 57'(m2d_6_ff) * 57'(ay_6_ff[24:0]);
         ny1_7_ff  <= 57'(m2d_6_ff) * 57'(ay_6_ff[49:25]);
         ny2_7_ff  <= 57'(m2d_6_ff) * 57'(ay_6_ff[74:50]);
         ny3_7_ff  <= 57'(m2d_6_ff) * 57'(ay_6_ff[96:75]);
         den_7_ff  <= den_6_ff;
         addx_7_ff <= addx_6_ff;
         addy_7_ff <= addy_6_ff;
         hit_7_ff  <= hit_6_ff;
         px_7_ff   <= px_6_ff;
         py_7_ff   <= py_6_ff;
         vx_7_ff   <= vx_6_ff;
         vy_7_ff   <= vy_6_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 8: numerator sums.
   // ------------------------------------------------------------------
   logic                     v8_ff;
   logic [128:0]             numx_8_ff, numy_8_ff;
   logic [93:0]              den_8_ff;
   logic                     addx_8_ff, addy_8_ff, hit_8_ff;
   logic signed [WORD_W-1:0] px_8_ff, py_8_ff, vx_8_ff, vy_8_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v8_ff <= 1'b0;
      end else if (en) begin
         v8_ff <= v7_ff;
      end
      if (en) begin
         numx_8_ff <= 129'(nx0_7_ff) + (129'(nx1_7_ff) << 25)
                    + (129'(nx2_7_ff) << 50) + (129'(nx3_7_ff) << 75);
         numy_8_ff <= 129'(ny0_7_ff) + (129'(ny1_7_ff) << 25)
                    + (129'(ny2_7_ff) << 50) + (129'(ny3_7_ff) << 75);
         den_8_ff  <= den_7_ff;
         addx_8_ff <= addx_7_ff;
         addy_8_ff <= addy_7_ff;
         hit_8_ff  <= hit_7_ff;
         px_8_ff   <= px_7_ff;
         py_8_ff   <= py_7_ff;
         vx_8_ff   <= vx_7_ff;
         vy_8_ff   <= vy_7_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 9: rounding offset. floor((2*|num| + den) / (2*den)) rounds the
   // impulse to nearest with ties away from zero.
   // ------------------------------------------------------------------
   logic                v9_ff;
   logic [NUM_W-1:0]    nnx_9_ff, nny_9_ff;
   logic [DEN_W-1:0]    dd_9_ff;
   decs_side_type       sidex_9_ff, sidey_9_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v9_ff <= 1'b0;
      end else if (en) begin
         v9_ff <= v8_ff;
      end
      if (en) begin
         nnx_9_ff         <= NUM_W'({numx_8_ff, 1'b0}) + NUM_W'(den_8_ff);
         nny_9_ff         <= NUM_W'({numy_8_ff, 1'b0}) + NUM_W'(den_8_ff);
         dd_9_ff          <= {den_8_ff, 1'b0};
         sidex_9_ff.hit   <= hit_8_ff;
         sidex_9_ff.add_q <= addx_8_ff;
         sidex_9_ff.vel   <= vx_8_ff;
         sidex_9_ff.pos   <= px_8_ff;
         sidey_9_ff.hit   <= hit_8_ff;
         sidey_9_ff.add_q <= addy_8_ff;
         sidey_9_ff.vel   <= vy_8_ff;
         sidey_9_ff.pos   <= py_8_ff;
      end
   end

   // ------------------------------------------------------------------
   // Impulse dividers, one per axis.
   // ------------------------------------------------------------------
   logic             divx_v, divy_v;
   logic [QUO_W-1:0] qx, qy;
   decs_side_type    sx, sy;

   decs_div u_div_x (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v9_ff),
      .in_num    (nnx_9_ff),
      .in_den    (dd_9_ff),
      .in_side   (sidex_9_ff),
      .out_valid (divx_v),
      .out_quot  (qx),
      .out_side  (sx)
   );

   decs_div u_div_y (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v9_ff),
      .in_num    (nny_9_ff),
      .in_den    (dd_9_ff),
      .in_side   (sidey_9_ff),
      .out_valid (divy_v),
      .out_quot  (qy),
      .out_side  (sy)
   );

   // ------------------------------------------------------------------
   // Stage A: apply the impulse and clip the velocity.
   // ------------------------------------------------------------------
   logic signed [37:0] qx_s, qy_s, vx_sum, vy_sum;
   assign qx_s   = $signed({2'b00, qx});
   assign qy_s   = $signed({2'b00, qy});
   assign vx_sum = !sx.hit ? 38'(sx.vel)
                 : (sx.add_q ? 38'(sx.vel) + qx_s : 38'(sx.vel) - qx_s);
   assign vy_sum = !sy.hit ? 38'(sy.vel)
                 : (sy.add_q ? 38'(sy.vel) + qy_s : 38'(sy.vel) - qy_s);

   logic                     va_ff;
   logic signed [WORD_W-1:0] nvx_a_ff, nvy_a_ff, px_a_ff, py_a_ff;
   logic                     sat_a_ff, hit_a_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
      end else if (en) begin
         va_ff <= divx_v;
      end
      if (en) begin
         if (vx_sum > VEL_MAX) begin
            nvx_a_ff <= VEL_MAX[31:0];
         end else if (vx_sum < VEL_MIN) begin
            nvx_a_ff <= VEL_MIN[31:0];
         end else begin
            nvx_a_ff <= vx_sum[31:0];
         end
         if (vy_sum > VEL_MAX) begin
            nvy_a_ff <= VEL_MAX[31:0];
         end else if (vy_sum < VEL_MIN) begin
            nvy_a_ff <= VEL_MIN[31:0];
         end else begin
            nvy_a_ff <= vy_sum[31:0];
         end
         sat_a_ff <= (vx_sum > VEL_MAX) || (vx_sum < VEL_MIN)
                  || (vy_sum > VEL_MAX) || (vy_sum < VEL_MIN);
         hit_a_ff <= sx.hit;
         px_a_ff  <= sx.pos;
         py_a_ff  <= sy.pos;
      end
   end

   // ------------------------------------------------------------------
   // Stage B: |v| * dt.
   // ------------------------------------------------------------------
   logic [32:0] vx_mag, vy_mag;
   assign vx_mag = nvx_a_ff[31] ? 33'(-33'(nvx_a_ff)) : 33'(nvx_a_ff);
   assign vy_mag = nvy_a_ff[31] ? 33'(-33'(nvy_a_ff)) : 33'(nvy_a_ff);

   logic                     vb_ff;
   logic [62:0]              prx_b_ff, pry_b_ff;
   logic signed [WORD_W-1:0] nvx_b_ff, nvy_b_ff, px_b_ff, py_b_ff;
   logic                     sat_b_ff, hit_b_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vb_ff <= 1'b0;
      end else if (en) begin
         vb_ff <= va_ff;
      end
      if (en) begin
         prx_b_ff <= 63'(vx_mag[31:0]) * 63'(time_step_ff);
         pry_b_ff <= 63'(vy_mag[31:0]) * 63'(time_step_ff);
         nvx_b_ff <= nvx_a_ff;
         nvy_b_ff <= nvy_a_ff;
         px_b_ff  <= px_a_ff;
         py_b_ff  <= py_a_ff;
         sat_b_ff <= sat_a_ff;
         hit_b_ff <= hit_a_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage C: round the step to Q16.16.
   // ------------------------------------------------------------------
   logic [63:0] rx_sum, ry_sum;
   assign rx_sum = 64'(prx_b_ff) + ROUND_HALF;
   assign ry_sum = 64'(pry_b_ff) + ROUND_HALF;

   logic                     vc_ff;
   logic [47:0]              stx_c_ff, sty_c_ff;
   logic signed [WORD_W-1:0] nvx_c_ff, nvy_c_ff, px_c_ff, py_c_ff;
   logic                     sat_c_ff, hit_c_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vc_ff <= 1'b0;
      end else if (en) begin
         vc_ff <= vb_ff;
      end
      if (en) begin
         stx_c_ff <= rx_sum[63:FRAC_W];
         sty_c_ff <= ry_sum[63:FRAC_W];
         nvx_c_ff <= nvx_b_ff;
         nvy_c_ff <= nvy_b_ff;
         px_c_ff  <= px_b_ff;
         py_c_ff  <= py_b_ff;
         sat_c_ff <= sat_b_ff;
         hit_c_ff <= hit_b_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage D: new position with clipping.
   // ------------------------------------------------------------------
   logic signed [49:0] stx_s, sty_s, nx_sum, ny_sum;
   logic               nx_clip, ny_clip;
   assign stx_s   = $signed({2'b00, stx_c_ff});
   assign sty_s   = $signed({2'b00, sty_c_ff});
   assign nx_sum  = nvx_c_ff[31] ? 50'(px_c_ff) - stx_s : 50'(px_c_ff) + stx_s;
   assign ny_sum  = nvy_c_ff[31] ? 50'(py_c_ff) - sty_s : 50'(py_c_ff) + sty_s;
   assign nx_clip = (nx_sum > POS_MAX) || (nx_sum < POS_MIN);
   assign ny_clip = (ny_sum > POS_MAX) || (ny_sum < POS_MIN);

   logic         vd_ff;
   rsp_item_type rd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vd_ff <= 1'b0;
      end else if (en) begin
         vd_ff <= vc_ff;
      end
      if (en) begin
         if (nx_sum > POS_MAX) begin
            rd_ff.next_x <= POS_MAX[31:0];
         end else if (nx_sum < POS_MIN) begin
            rd_ff.next_x <= POS_MIN[31:0];
         end else begin
            rd_ff.next_x <= nx_sum[31:0];
         end
         if (ny_sum > POS_MAX) begin
            rd_ff.next_y <= POS_MAX[31:0];
         end else if (ny_sum < POS_MIN) begin
            rd_ff.next_y <= POS_MIN[31:0];
         end else begin
            rd_ff.next_y <= ny_sum[31:0];
         end
         rd_ff.next_vx   <= nvx_c_ff;
         rd_ff.next_vy   <= nvy_c_ff;
         rd_ff.collided  <= hit_c_ff;
         rd_ff.saturated <= sat_c_ff || nx_clip || ny_clip;
      end
   end

   // ------------------------------------------------------------------
   // Output register with skid register. The pipeline advances whenever
   // the skid register is empty, so req_tready comes from a flop.
   // ------------------------------------------------------------------
   logic         out_v_ff, skid_v_ff;
   rsp_item_type out_ff, skid_ff;

   assign en         = !skid_v_ff;
   assign req_tready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (!out_v_ff || rsp_tready) begin
         if (skid_v_ff) begin
            out_v_ff  <= 1'b1;
            skid_v_ff <= 1'b0;
         end else begin
            out_v_ff <= vd_ff;
         end
      end else if (vd_ff && en) begin
         skid_v_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_v_ff || rsp_tready) begin
         out_ff <= skid_v_ff ? skid_ff : rd_ff;
      end else if (en) begin
         skid_ff <= rd_ff;
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = {out_ff.next_vy, out_ff.next_vx, out_ff.next_y, out_ff.next_x};
   assign rsp_tuser  = {out_ff.saturated, out_ff.collided};

`ifndef SYNTHESIS
   // A parked beat always sits behind a held output beat.
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |-> out_v_ff)
      else $error("skid register full while output register empty");

   // While the pipeline is frozen the last stage holds its beat.
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(vd_ff))
      else $error("last pipeline stage changed during a stall");

   // Both axis dividers carry the same beats.
   a_div_lockstep: assert property (@(posedge clock) disable iff (reset)
      divx_v == divy_v)
      else $error("axis dividers out of step");

   // A result beat is parked only when the output beat was held.
   a_skid_fill: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_v_ff) |-> $past(out_v_ff && !rsp_tready))
      else $error("skid register filled while output drained");
`endif

endmodule

`default_nettype wire

@@ sv/decs_div.sv @@
// ============================================================================
// decs_div
// Pipelined restoring divider, one quotient bit per register stage.
// ============================================================================
`default_nettype none

module decs_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       en,
   input  logic                       in_valid,
   input  logic [decs_pkg::NUM_W-1:0] in_num,
   input  logic [decs_pkg::DEN_W-1:0] in_den,
   input  decs_pkg::decs_side_type    in_side,
   output logic                       out_valid,
   output logic [decs_pkg::QUO_W-1:0] out_quot,
   output decs_pkg::decs_side_type    out_side
);
   import decs_pkg::*;

   logic [NUM_W-1:0] rem_ff   [QUO_W];
   logic [DEN_W-1:0] den_ff   [QUO_W];
   logic [QUO_W-1:0] quot_ff  [QUO_W];
   decs_side_type    side_ff  [QUO_W];
   logic             valid_ff [QUO_W];

   for (genvar k = 0; k < QUO_W; k++) begin : g_bit
      logic [NUM_W-1:0] rem_prev;
      logic [DEN_W-1:0] den_prev;
      logic [QUO_W-1:0] quot_prev;
      decs_side_type    side_prev;
      logic             valid_prev;
      logic [NUM_W-1:0] trial;

      if (k == 0) begin : g_first
         assign rem_prev   = in_num;
         assign den_prev   = in_den;
         assign quot_prev  = '0;
         assign side_prev  = in_side;
         assign valid_prev = in_valid;
      end else begin : g_next
         assign rem_prev   = rem_ff[k-1];
         assign den_prev   = den_ff[k-1];
         assign quot_prev  = quot_ff[k-1];
         assign side_prev  = side_ff[k-1];
         assign valid_prev = valid_ff[k-1];
      end

      // Divisor aligned to the quotient bit settled in this stage.
      assign trial = NUM_W'(den_prev) << (QUO_W - 1 - k);

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= valid_prev;
         end
         if (en) begin
            if (rem_prev >= trial) begin
               rem_ff[k]  <= rem_prev - trial;
               quot_ff[k] <= quot_prev | (QUO_W'(1) << (QUO_W - 1 - k));
            end else begin
               rem_ff[k]  <= rem_prev;
               quot_ff[k] <= quot_prev;
            end
            den_ff[k]  <= den_prev;
            side_ff[k] <= side_prev;
         end
      end
   end

   assign out_valid = valid_ff[QUO_W-1];
   assign out_quot  = quot_ff[QUO_W-1];
   assign out_side  = side_ff[QUO_W-1];

endmodule

`default_nettype wire

@@ sim/tb_disc_elastic_collision_step_core.sv @@
// ============================================================================
// tb_disc_elastic_collision_step_core
// Self-checking testbench for the disc collision step core. A scoreboard
// predicts every result beat with wide exact integer arithmetic, and random
// stalls on both streams plus several time step settings exercise the core.
// ============================================================================
`timescale 1ns / 1ps

typedef logic signed [255:0] wide_type;

typedef struct {
   logic [31:0] nx, ny, nvx, nvy;
   logic        hit, sat;
} disc_state_type;

class collision_scoreboard;
   wide_type       step_size;
   disc_state_type expected_q[$];
   int             mismatches;
   int             checked;
   int             hits;
   int             clips;

   function new();
      step_size  = decs_pkg::TIME_STEP_RESET;
      mismatches = 0;
      checked    = 0;
      hits       = 0;
      clips      = 0;
   endfunction

   function wide_type clip32(wide_type v, inout logic sat);
      wide_type hi;
      wide_type lo;
      hi = 32'sh7FFFFFFF;
      lo = -hi - 1;
      if (v > hi) begin
         sat = 1'b1;
         return hi;
      end
      if (v < lo) begin
         sat = 1'b1;
         return lo;
      end
      return v;
   endfunction

   // Velocity minus the elastic impulse on one axis, rounded half away from zero.
   function wide_type kicked_speed(wide_type v, wide_type d_axis, wide_type dot, wide_type m2,
                                   wide_type den);
      wide_type num;
      wide_type mag;
      wide_type q;
      num = 2 * m2 * dot * d_axis;
      mag = (num < 0) ? -num : num;
      q   = (2 * mag + den) / (2 * den);
      return (num < 0) ? v + q : v - q;
   endfunction

   function wide_type advanced_pos(wide_type p, wide_type v, inout logic sat);
      wide_type mag;
      wide_type s;
      mag = (v < 0) ? -v : v;
      s   = (mag * step_size + 32768) >>> 16;
      return clip32(p + ((v < 0) ? -s : s), sat);
   endfunction

   // Works out the result of one accepted request beat.
   function void note_request(logic [decs_pkg::REQ_DATA_W-1:0] d, logic partner);
      wide_type px, py, vx, vy, m1, ox, oy, ovx, ovy, m2, cd;
      wide_type dx, dy, d2, dot, msum, den, nvx, nvy;
      disc_state_type e;
      px  = $signed(d[31:0]);
      py  = $signed(d[63:32]);
      vx  = $signed(d[95:64]);
      vy  = $signed(d[127:96]);
      m1  = d[158:128];
      ox  = $signed(d[190:159]);
      oy  = $signed(d[222:191]);
      ovx = $signed(d[254:223]);
      ovy = $signed(d[286:255]);
      m2  = d[317:287];
      cd  = d[348:318];
      e.hit = 1'b0;
      e.sat = 1'b0;
      nvx = vx;
      nvy = vy;
      if (partner) begin
         dx  = px - ox;
         dy  = py - oy;
         d2  = dx * dx + dy * dy;
         dot = dx * (vx - ovx) + dy * (vy - ovy);
         if (d2 < cd * cd && dot < 0) begin
            e.hit = 1'b1;
            if (d2 == 0) d2 = 1;
            msum = m1 + m2;
            if (msum == 0) msum = 1;
            den = msum * d2;
            nvx = kicked_speed(vx, dx, dot, m2, den);
            nvy = kicked_speed(vy, dy, dot, m2, den);
         end
      end
      nvx   = clip32(nvx, e.sat);
      nvy   = clip32(nvy, e.sat);
      e.nvx = nvx[31:0];
      e.nvy = nvy[31:0];
      px    = advanced_pos(px, nvx, e.sat);
      py    = advanced_pos(py, nvy, e.sat);
      e.nx  = px[31:0];
      e.ny  = py[31:0];
      expected_q.push_back(e);
   endfunction

   function void report(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s expected %h actual %h", name, want, got);
         mismatches++;
      end
   endfunction

   function void check_result(logic [decs_pkg::RSP_DATA_W-1:0] d,
                              logic [decs_pkg::RSP_USER_W-1:0] u);
      disc_state_type e;
      if (expected_q.size() == 0) begin
         $error("result beat with no pending request, data %h", d);
         mismatches++;
         return;
      end
      e = expected_q.pop_front();
      checked++;
      if (e.hit) hits++;
      if (e.sat) clips++;
      report("next_x", e.nx, d[31:0]);
      report("next_y", e.ny, d[63:32]);
      report("next_vx", e.nvx, d[95:64]);
      report("next_vy", e.nvy, d[127:96]);
      report("collided", 32'(e.hit), 32'(u[0]));
      report("saturated", 32'(e.sat), 32'(u[1]));
   endfunction
endclass

module tb_disc_elastic_collision_step_core;

   localparam int CYCLE_LIMIT = 600000;
   localparam int DRAIN_WAIT  = 80;

   typedef struct {
      logic [31:0] x, y, vx, vy;
      logic [30:0] m;
      logic        partner;
      logic [31:0] ox, oy, ovx, ovy;
      logic [30:0] om, cd;
   } disc_req_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic [decs_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic                            req_tuser = 1'b0;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [decs_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic [decs_pkg::RSP_USER_W-1:0] rsp_tuser;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [decs_pkg::MAG_W-1:0]      csr_data = '0;
   logic                            csr_valid = 1'b0;
   logic                            csr_ready;

   collision_scoreboard sb = new();

   int  send_idle = 0;        // percent of cycles the request side idles
   int  recv_idle = 0;        // percent of cycles the result side stalls
   bit  hold_request = 1'b0;  // asks the result side for one long stall
   int  hold_left = 0;
   int  accepted = 0;
   int  cycles = 0;

   disc_elastic_collision_step_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_data   (csr_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready)
   );

   always #2 clock = ~clock;

   // Watchdog: a run that stops making progress ends as a failure.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("disc_elastic_collision_step_core test failed");
         $finish;
      end
   end

   // Request beats are predicted at the edge where they are accepted.
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         sb.note_request(req_tdata, req_tuser);
         accepted <= accepted + 1;
      end
   end

   // Result beats are checked in arrival order.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata, rsp_tuser);
   end

   // Result side backpressure. A long stall lets the pipeline and its skid
   // register fill so that the core has to drop req_tready.
   always @(negedge clock) begin
      if (hold_request) begin
         hold_left    = 400;
         hold_request = 1'b0;
      end
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left  = hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle);
      end
   end

   // Offers one beat, idling first at the current rate. tvalid stays high
   // across back-to-back beats.
   task automatic send_disc(input disc_req_type r);
      int seen;
      while ($urandom_range(99) < send_idle) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tdata  = {3'b000, r.cd, r.om, r.ovy, r.ovx, r.oy, r.ox, r.m, r.vy, r.vx, r.y, r.x};
      req_tuser  = r.partner;
      req_tvalid = 1'b1;
      seen       = accepted;
      @(negedge clock);
      while (accepted == seen) @(negedge clock);
   endtask

   task automatic drain_results();
      req_tvalid = 1'b0;
      while (sb.expected_q.size() != 0) @(negedge clock);
      repeat (DRAIN_WAIT) @(negedge clock);
   endtask

   // Register write while the core is idle; the predictor follows at the
   // same edge.
   task automatic write_time_step(input logic [30:0] value);
      csr_data  = value;
      csr_valid = 1'b1;
      do @(posedge clock); while (!csr_ready);
      sb.step_size = value;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   function automatic logic [31:0] spread(input int top_bit);
      logic [31:0] v;
      v = $urandom;
      if (top_bit < 31) v = $signed(v) >>> (31 - top_bit);
      return v;
   endfunction

   // Mostly pairs within reach of each other so that the collision branch is
   // taken often; the rest are unconstrained beats.
   function automatic disc_req_type random_disc();
      disc_req_type r;
      int           reach;
      logic [31:0]  dx, dy;
      r.x = $urandom; r.y = $urandom; r.vx = $urandom; r.vy = $urandom;
      r.ox = $urandom; r.oy = $urandom; r.ovx = $urandom; r.ovy = $urandom;
      r.m = 31'($urandom); r.om = 31'($urandom); r.cd = 31'($urandom);
      r.partner = ($urandom_range(9) != 0);
      if ($urandom_range(4) != 0) begin
         reach = int'($urandom_range(4, 26));
         dx    = spread(reach);
         dy    = spread(reach);
         r.x   = r.ox + dx;
         r.y   = r.oy + dy;
         r.cd  = 31'($urandom_range(0, (1 << (reach + 2)) - 1));
         r.vx  = spread(int'($urandom_range(6, 31)));
         r.vy  = spread(int'($urandom_range(6, 31)));
         r.ovx = spread(int'($urandom_range(6, 31)));
         r.ovy = spread(int'($urandom_range(6, 31)));
         if ($urandom_range(1)) begin
            r.m  = 31'($urandom_range(1, 1 << 22));
            r.om = 31'($urandom_range(1, 1 << 22));
         end
      end
      return r;
   endfunction

   function automatic disc_req_type make_disc(logic [31:0] x, y, vx, vy, logic [30:0] m,
                                              logic partner, logic [31:0] ox, oy, ovx, ovy,
                                              logic [30:0] om, cd);
      disc_req_type r;
      r.x = x; r.y = y; r.vx = vx; r.vy = vy; r.m = m; r.partner = partner;
      r.ox = ox; r.oy = oy; r.ovx = ovx; r.ovy = ovy; r.om = om; r.cd = cd;
      return r;
   endfunction

   initial begin
      disc_req_type directed_q[$];
      logic [30:0]  steps[6];
      int           seg;
      int           n;

      steps = '{31'd0, 31'h7FFFFFFF, 31'd65536, 31'd655, 31'd1, 31'h00123456};
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Extremes of every field.
      directed_q.push_back(make_disc('1, '1, '1, '1, '1, 1, '1, '1, '1, '1, '1, '1));
      directed_q.push_back(make_disc('0, '0, '0, '0, '0, 0, '0, '0, '0, '0, '0, '0));
      directed_q.push_back(make_disc(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000,
                                     31'h7FFFFFFF, 1, 32'h80000000, 32'h7FFFFFFF,
                                     32'h80000000, 32'h7FFFFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF));
      // No partner: junk partner fields must be ignored.
      directed_q.push_back(make_disc(32'h10000, 0, 32'h20000, 32'hFFFF0000, 31'h10000, 0,
                                     32'h10000, 0, 32'h80000000, 32'h7FFFFFFF, 1, '1));
      // Head-on approach along x, equal masses.
      directed_q.push_back(make_disc(0, 0, 32'h10000, 0, 31'h10000, 1, 32'h8000, 0,
                                     32'hFFFF0000, 0, 31'h10000, 31'h10000));
      // Oblique approach, unequal masses.
      directed_q.push_back(make_disc(32'h1000, 32'h3000, 32'h30000, 32'h10000, 31'h30000, 1,
                                     32'h4000, 32'h1000, 32'hFFFE0000, 0, 31'h8000,
                                     31'h20000));
      // Overlapping but separating: no impulse.
      directed_q.push_back(make_disc(0, 0, 32'hFFFF0000, 0, 31'h10000, 1, 32'h8000, 0,
                                     32'h10000, 0, 31'h10000, 31'h10000));
      // Zero distance.
      directed_q.push_back(make_disc(32'h5000, 32'h5000, 32'h10000, 32'h10000, 31'h10000, 1,
                                     32'h5000, 32'h5000, 0, 0, 31'h10000, 31'h10000));
      // Both masses zero, and one mass zero.
      directed_q.push_back(make_disc(0, 0, 32'h10000, 0, 0, 1, 32'h8000, 0,
                                     32'hFFFF0000, 0, 0, 31'h10000));
      directed_q.push_back(make_disc(0, 0, 32'h10000, 0, 0, 1, 32'h8000, 0,
                                     32'hFFFF0000, 0, 31'h10000, 31'h10000));
      // Zero radius sum.
      directed_q.push_back(make_disc(0, 0, 32'h10000, 0, 31'h10000, 1, 32'h1, 0,
                                     32'hFFFF0000, 0, 31'h10000, 0));
      // Huge relative speed with a light own disc: the velocity clips.
      directed_q.push_back(make_disc(0, 0, 32'h7FFFFFFF, 0, 1, 1, 32'h1, 0,
                                     32'h80000000, 0, 31'h7FFFFFFF, 31'h7FFFFFFF));
      // Position near the rails with full speed.
      directed_q.push_back(make_disc(32'h7FFFFF00, 32'h80000100, 32'h7FFFFFFF, 32'h80000000,
                                     31'h10000, 0, 0, 0, 0, 0, 1, 0));
      // Smallest nonzero speeds: rounding of the position step.
      directed_q.push_back(make_disc(0, 0, 32'h1, 32'hFFFFFFFF, 31'h10000, 0, 0, 0, 0, 0,
                                     1, 0));

      // Directed beats run at the reset time step, then at the largest time step.
      foreach (directed_q[i]) send_disc(directed_q[i]);
      drain_results();
      write_time_step(31'h7FFFFFFF);
      foreach (directed_q[i]) send_disc(directed_q[i]);
      drain_results();

      for (seg = 0; seg < 6; seg++) begin
         send_idle = (seg < 2) ? 32 : (seg < 4) ? 68 : 0;
         recv_idle = (seg < 2) ? 68 : (seg < 4) ? 32 : 0;
         write_time_step(steps[seg]);
         for (n = 0; n < 145; n++) begin
            if (seg == 4 && n == 20) hold_request = 1'b1;
            if (seg == 2 && n == 70) drain_results();
            send_disc(random_disc());
         end
         drain_results();
      end

      $display("Checked %0d result beats (%0d with impulse, %0d clipped) over six time steps.",
               sb.checked, sb.hits, sb.clips);
      if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
         $display("disc_elastic_collision_step_core test passed");
      end else begin
         $display("disc_elastic_collision_step_core test failed");
      end
      $finish;
   end

endmodule

@@ disc_elastic_collision_step_core.f @@
sv/decs_pkg.sv
sv/decs_div.sv
sv/disc_elastic_collision_step_core.sv
sim/tb_disc_elastic_collision_step_core.sv
